// ----- rtl/core/blkmed_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blkmed_pkg
// shared types and constants of the block median adc filter
// ----------------------------------------------------------------------------
package blkmed_pkg;

	localparam int CHANNELS   = 4;
	localparam int MAX_WINDOW = 16;

	localparam int CH_W     = $clog2(CHANNELS);
	localparam int IDX_W    = $clog2(MAX_WINDOW);
	localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
	localparam int ADDR_W   = CH_W + IDX_W;
	localparam int DEPTH    = CHANNELS * MAX_WINDOW;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 5;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CFG_W-1:0]   WINDOW_LENGTH_RST = CFG_W'(5);
	localparam logic [PADDR_W-1:0] REG_WINDOW_LENGTH = PADDR_W'(0);

	typedef struct packed {
		logic [1:0]          channel;
		logic signed [15:0]  sample;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          result_channel;
		logic signed [15:0]  filtered_value;
		logic                updated;
	} out_item_t;

	typedef struct packed {
		logic vld;
		logic last;
	} rank_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMBINE,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/core/blkmed_window_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blkmed_window_ram
// per-channel sample windows, one write port and two registered read ports
// ----------------------------------------------------------------------------
module blkmed_window_ram
	import blkmed_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [ADDR_W-1:0]          waddr,
	input  wire logic signed [SAMPLE_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0]          raddr_a,
	input  wire logic [ADDR_W-1:0]          raddr_b,
	output logic signed [SAMPLE_W-1:0]      rdata_a_s1,
	output logic signed [SAMPLE_W-1:0]      rdata_b_s1
);

	logic signed [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_s1 <= mem[raddr_a];
		rdata_b_s1 <= mem[raddr_b];
	end

endmodule
`default_nettype wire

// ----- rtl/core/blkmed_rank_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// blkmed_rank_unit
// shared compare unit: ranks each candidate against the window and picks
// the two middle values, then gives their floor mean
// ----------------------------------------------------------------------------
module blkmed_rank_unit
	import blkmed_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire rank_ctl_t                  ctl_s1,
	input  wire logic signed [SAMPLE_W-1:0] cand_s1,
	input  wire logic signed [SAMPLE_W-1:0] other_s1,
	input  wire logic [IDX_W-1:0]           k_lo,
	input  wire logic [IDX_W-1:0]           k_hi,
	output logic signed [SAMPLE_W-1:0]      median
);

	logic [CNT_W-1:0]           lt_q, le_q;
	logic [CNT_W-1:0]           lt_next, le_next;
	logic signed [SAMPLE_W:0]   diff;
	logic                       is_lt, is_le;
	logic signed [SAMPLE_W-1:0] lo_q, hi_q;
	logic signed [SAMPLE_W:0]   sum;

	always_comb begin
		diff    = {other_s1[SAMPLE_W-1], other_s1} - {cand_s1[SAMPLE_W-1], cand_s1};
		is_lt   = diff[SAMPLE_W];
		is_le   = is_lt | (diff == '0);
		lt_next = lt_q + CNT_W'(is_lt);
		le_next = le_q + CNT_W'(is_le);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
			le_q <= '0;
		end else if (ctl_s1.vld) begin
			if (ctl_s1.last) begin
				lt_q <= '0;
				le_q <= '0;
			end else begin
				lt_q <= lt_next;
				le_q <= le_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vld && ctl_s1.last) begin
			if (lt_next <= CNT_W'(k_lo) && CNT_W'(k_lo) < le_next) begin
				lo_q <= cand_s1;
			end
			if (lt_next <= CNT_W'(k_hi) && CNT_W'(k_hi) < le_next) begin
				hi_q <= cand_s1;
			end
		end
	end

	// floor mean of the two middle values
	assign sum    = {lo_q[SAMPLE_W-1], lo_q} + {hi_q[SAMPLE_W-1], hi_q};
	assign median = sum[SAMPLE_W:1];

endmodule
`default_nettype wire

// ----- rtl/core/block_median_adc_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// block_median_adc_filter
// per-channel block median filter with a fast first-sample path
// ----------------------------------------------------------------------------
// flow: a first sample or a sample that leaves the window open goes from IDLE
//   to FINISH, then to the output register; a sample that completes the window
//   passes SCAN, DRAIN and COMBINE before FINISH, SCAN comparing len*len pairs,
//   len being the effective window length; a new transaction is taken only in
//   IDLE; the single rank compare unit checks one pair of entries per cycle
// reset: clears channel results, fill counts and first-sample flags, window
//   length returns to 5; window memory is not cleared
// ----------------------------------------------------------------------------
module block_median_adc_filter
	import blkmed_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_item_t           in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_item_t               out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	state_t                     state_q, state_d;
	logic [CFG_W-1:0]           wl_q;
	logic [CNT_W-1:0]           len_eff, len_q;
	logic [CH_W-1:0]            ch_q;
	logic                       upd_q;
	logic                       primed_q [CHANNELS];
	logic [IDX_W-1:0]           fill_q [CHANNELS];
	logic signed [SAMPLE_W-1:0] result_q [CHANNELS];
	logic [IDX_W-1:0]           i_q, j_q;
	logic [IDX_W-1:0]           lm1, k_lo, k_hi;
	logic [CNT_W-1:0]           mid;
	logic                       accept, cfg_we, out_free;
	logic [CH_W-1:0]            acc_ch;
	logic [IDX_W-1:0]           cur_fill;
	logic [CNT_W-1:0]           fill_inc;
	logic                       win_full;
	rank_ctl_t                  issue_ctl, ctl_s1;
	logic signed [SAMPLE_W-1:0] rd_a_s1, rd_b_s1;
	logic signed [SAMPLE_W-1:0] median;
	logic                       out_valid_q;
	out_item_t                  out_data_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready & (paddr == REG_WINDOW_LENGTH);
	assign prdata = (paddr == REG_WINDOW_LENGTH) ? PDATA_W'(wl_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WINDOW_LENGTH_RST;
		end else if (cfg_we) begin
			wl_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		if (wl_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (int'(wl_q) > MAX_WINDOW) begin
			len_eff = CNT_W'(MAX_WINDOW);
		end else begin
			len_eff = CNT_W'(wl_q);
		end
	end

	// input transaction decode
	assign acc_ch   = in_data.channel;
	assign cur_fill = fill_q[acc_ch];
	assign fill_inc = CNT_W'(cur_fill) + CNT_W'(1);
	assign win_full = fill_inc >= len_eff;
	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	assign lm1  = IDX_W'(len_q - CNT_W'(1));
	assign mid  = len_q >> 1;
	assign k_hi = mid[IDX_W-1:0];
	assign k_lo = len_q[0] ? k_hi : k_hi - IDX_W'(1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		issue_ctl = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (primed_q[acc_ch] && win_full) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				issue_ctl.vld  = 1'b1;
				issue_ctl.last = (j_q == lm1);
				if (j_q == lm1 && i_q == lm1) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMBINE;
			end
			ST_COMBINE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// scan counters and item context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			ch_q   <= '0;
			upd_q  <= 1'b0;
			len_q  <= CNT_W'(1);
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= issue_ctl;
			if (accept) begin
				i_q   <= '0;
				j_q   <= '0;
				ch_q  <= acc_ch;
				upd_q <= ~primed_q[acc_ch] | win_full;
				len_q <= len_eff;
			end else if (state_q == ST_SCAN) begin
				if (j_q == lm1) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

	// per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				primed_q[c] <= 1'b0;
				fill_q[c]   <= '0;
				result_q[c] <= '0;
			end
		end else begin
			if (accept) begin
				if (!primed_q[acc_ch]) begin
					primed_q[acc_ch] <= 1'b1;
					result_q[acc_ch] <= in_data.sample;
				end else begin
					fill_q[acc_ch] <= win_full ? '0 : fill_inc[IDX_W-1:0];
				end
			end
			if (state_q == ST_COMBINE) begin
				result_q[ch_q] <= median;
			end
		end
	end

	blkmed_window_ram u_ram (
		.clk        (clk),
		.we         (accept & primed_q[acc_ch]),
		.waddr      ({acc_ch, cur_fill}),
		.wdata      (in_data.sample),
		.raddr_a    ({ch_q, i_q}),
		.raddr_b    ({ch_q, j_q}),
		.rdata_a_s1 (rd_a_s1),
		.rdata_b_s1 (rd_b_s1)
	);

	blkmed_rank_unit u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.cand_s1  (rd_a_s1),
		.other_s1 (rd_b_s1),
		.k_lo     (k_lo),
		.k_hi     (k_hi),
		.median   (median)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_data_q.result_channel <= ch_q;
			out_data_q.filtered_value <= result_q[ch_q];
			out_data_q.updated        <= upd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire
